FILE: sv/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg - shared types and codes of the terminal line editor
// Key codes, escape phases, result kinds and the command that drives the
// row of character cells.
// ----------------------------------------------------------------------------
package tle_pkg;

  // Operation selector on the input stream
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds
  localparam logic [1:0] ST_EDIT  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ABORT = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  // Escape sequence phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_ESC     = 2'd1;
  localparam logic [1:0] PH_BRACKET = 2'd2;
  localparam logic [1:0] PH_DIGIT   = 2'd3;

  // Key codes
  localparam logic [7:0] KEY_NUL       = 8'd0;
  localparam logic [7:0] KEY_ABORT     = 8'd4;
  localparam logic [7:0] KEY_TAB       = 8'd9;
  localparam logic [7:0] KEY_NEWLINE   = 8'd10;
  localparam logic [7:0] KEY_ESC       = 8'd27;
  localparam logic [7:0] KEY_BACKSPACE = 8'd127;
  localparam logic [7:0] KEY_ABORT_ALT = 8'd255;
  localparam logic [7:0] CHAR_BRACKET  = 8'h5B;
  localparam logic [7:0] CHAR_TILDE    = 8'h7E;
  localparam logic [7:0] CHAR_0        = 8'h30;
  localparam logic [7:0] CHAR_3        = 8'h33;
  localparam logic [7:0] CHAR_9        = 8'h39;
  localparam logic [7:0] CHAR_C        = 8'h43;
  localparam logic [7:0] CHAR_D        = 8'h44;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic ins;  // open a gap at the position and write the key there
    logic del;  // close the gap at the position
  } edit_cmd_t;

endpackage

FILE: sv/terminal_line_editor.sv
// ----------------------------------------------------------------------------
// terminal_line_editor - keystroke line editor with ANSI cursor sequences
// Edits one line held in a row of character cells; inserts and deletes shift
// the whole row at once, and a read returns one stored character.
// ----------------------------------------------------------------------------
// Each result is registered and appears on the output in the cycle after its input transfer.
// Throughput: one item per cycle; each edit shifts the whole cell row at once
//   and the output register takes a new result whenever it is empty or drained.
// Reset clears cursor, length, escape phase and output valid; the character
//   cells are not cleared and hold nothing readable until written.
module terminal_line_editor #(
  parameter int LINE_CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // key_byte[7:0], read_index[17:8], zero pad
  input  logic [0:0]  s_axis_tuser,   // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // cursor_position[9:0], line_length[19:10],
                                      // read_char[27:20], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import tle_pkg::*;

  localparam int CW   = $clog2(LINE_CAPACITY);
  localparam int CMPW = (CW > 10) ? CW : 10;

  logic          accept_in;
  logic          key_step;
  logic [7:0]    key_byte;
  logic [9:0]    read_index;
  edit_cmd_t     cmd;
  logic [CW-1:0] edit_pos;
  logic [1:0]    status_next;
  logic [CW-1:0] cursor_next;
  logic [CW-1:0] length_next;
  logic [CW-1:0] cursor;
  logic [CW-1:0] length;
  logic [7:0]    cell_q     [LINE_CAPACITY];
  logic [7:0]    left_in    [LINE_CAPACITY];
  logic [7:0]    right_in   [LINE_CAPACITY];
  logic          read_hit;
  logic [7:0]    read_data;
  logic [1:0]    out_status;
  logic [9:0]    out_cursor;
  logic [9:0]    out_length;
  logic [7:0]    out_char;

  assign key_byte   = s_axis_tdata[7:0];
  assign read_index = s_axis_tdata[17:8];

  // Take a new item whenever the output register is free or draining
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign key_step      = accept_in && (s_axis_tuser[0] == OP_KEY);

  tle_ctrl #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .CW            (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (key_step),
    .key_byte    (key_byte),
    .cmd         (cmd),
    .edit_pos    (edit_pos),
    .status_next (status_next),
    .cursor_next (cursor_next),
    .length_next (length_next),
    .cursor      (cursor),
    .length      (length)
  );

  // Row of character cells, each wired to its neighbors
  for (genvar i = 0; i < LINE_CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = 8'h00;
    end else begin : g_mid_l
      assign left_in[i] = cell_q[i-1];
    end
    if (i == LINE_CAPACITY - 1) begin : g_last
      assign right_in[i] = 8'h00;
    end else begin : g_mid_r
      assign right_in[i] = cell_q[i+1];
    end
    tle_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .pos   (edit_pos),
      .key   (key_byte),
      .left  (left_in[i]),
      .right (right_in[i]),
      .q     (cell_q[i])
    );
  end

  // Select the character to read, zero beyond the line end
  assign read_hit  = CMPW'(read_index) < CMPW'(length);
  assign read_data = read_hit ? cell_q[CW'(read_index)] : 8'h00;

  // Hold the result until the output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept_in) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      if (s_axis_tuser[0] == OP_READ) begin
        out_status <= ST_READ;
        out_cursor <= 10'(cursor);
        out_length <= 10'(length);
        out_char   <= read_data;
      end else begin
        out_status <= status_next;
        out_cursor <= 10'(cursor_next);
        out_length <= 10'(length_next);
        out_char   <= 8'h00;
      end
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {4'h0, out_char, out_length, out_cursor};

  a_char_only_on_read: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_status != ST_READ) |-> out_char == 8'h00)
    else $error("character returned on a keystroke result");

  a_read_reply: assert property (@(posedge clk) disable iff (rst)
    accept_in && (s_axis_tuser[0] == OP_READ) |=> m_axis_tvalid && (out_status == ST_READ))
    else $error("read transfer without a read reply");

  a_read_beyond_end: assert property (@(posedge clk) disable iff (rst)
    accept_in && (s_axis_tuser[0] == OP_READ) && !read_hit |=> out_char == 8'h00)
    else $error("read beyond line end returned data");

endmodule

FILE: sv/tle_cell.sv
// ----------------------------------------------------------------------------
// tle_cell - one character cell of the line row
// Holds one stored character and takes its left or right neighbor's value
// when the row shifts for an insert or a delete.
// ----------------------------------------------------------------------------
module tle_cell #(
  parameter int CW  = 10,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  tle_pkg::edit_cmd_t  cmd,
  input  logic [CW-1:0]       pos,
  input  logic [7:0]          key,
  input  logic [7:0]          left,
  input  logic [7:0]          right,
  output logic [7:0]          q
);
  import tle_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [7:0] q_next;

  // Pick the new content: key at the gap, shift right past it, shift left on delete
  always_comb begin
    q_next = q;
    if (cmd.ins) begin
      if (MY_IDX == pos) begin
        q_next = key;
      end else if (MY_IDX > pos) begin
        q_next = left;
      end
    end else if (cmd.del && (MY_IDX >= pos)) begin
      q_next = right;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: sv/tle_ctrl.sv
// ----------------------------------------------------------------------------
// tle_ctrl - cursor, length and escape decoding of the line editor
// Decodes one keystroke against the cursor and length, moves them and issues
// the shift command for the cell row.
// ----------------------------------------------------------------------------
module tle_ctrl #(
  parameter int LINE_CAPACITY = 1024,
  parameter int CW            = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          key_byte,
  output tle_pkg::edit_cmd_t  cmd,
  output logic [CW-1:0]       edit_pos,
  output logic [1:0]          status_next,
  output logic [CW-1:0]       cursor_next,
  output logic [CW-1:0]       length_next,
  output logic [CW-1:0]       cursor,
  output logic [CW-1:0]       length
);
  import tle_pkg::*;

  localparam logic [CW-1:0] LEN_LIMIT = CW'(LINE_CAPACITY - 1);
  localparam logic [CW-1:0] ONE       = CW'(1);

  logic [1:0]    phase;
  logic [7:0]    held;
  logic          finished;
  logic [1:0]    phase_next;
  logic [7:0]    held_next;
  logic          finished_next;
  logic [CW-1:0] c0;
  logic [CW-1:0] l0;
  logic [1:0]    ph0;
  logic [7:0]    h0;
  edit_cmd_t     cmd_raw;

  // Start from an empty line when the last one has ended
  always_comb begin
    c0  = finished ? '0 : cursor;
    l0  = finished ? '0 : length;
    ph0 = finished ? PH_IDLE : phase;
    h0  = finished ? 8'h00 : held;
  end

  // Decode the keystroke
  always_comb begin
    cursor_next   = c0;
    length_next   = l0;
    phase_next    = ph0;
    held_next     = h0;
    finished_next = 1'b0;
    status_next   = ST_EDIT;
    cmd_raw       = '0;
    edit_pos      = c0;
    unique case (ph0)
      PH_ESC: begin
        phase_next = (key_byte == CHAR_BRACKET) ? PH_BRACKET : PH_IDLE;
      end
      PH_BRACKET: begin
        phase_next = PH_IDLE;
        case (key_byte) inside
          CHAR_C: begin
            if (c0 < l0) cursor_next = c0 + ONE;
          end
          CHAR_D: begin
            if (c0 != '0) cursor_next = c0 - ONE;
          end
          [CHAR_0:CHAR_9]: begin
            held_next  = key_byte;
            phase_next = PH_DIGIT;
          end
          default: ;
        endcase
      end
      PH_DIGIT: begin
        if ((h0 == CHAR_3) && (key_byte == CHAR_TILDE) && (c0 < l0)) begin
          cmd_raw.del = 1'b1;
          length_next = l0 - ONE;
        end
        held_next  = 8'h00;
        phase_next = PH_IDLE;
      end
      default: begin
        case (key_byte) inside
          KEY_ABORT, KEY_ABORT_ALT: begin
            finished_next = 1'b1;
            status_next   = ST_ABORT;
          end
          KEY_NEWLINE: begin
            finished_next = 1'b1;
            status_next   = ST_DONE;
          end
          KEY_NUL, KEY_TAB: ;
          KEY_BACKSPACE: begin
            if (c0 != '0) begin
              cursor_next = c0 - ONE;
              edit_pos    = c0 - ONE;
              cmd_raw.del = 1'b1;
              length_next = l0 - ONE;
            end
          end
          KEY_ESC: begin
            phase_next = PH_ESC;
          end
          default: begin
            if (l0 < LEN_LIMIT) begin
              cmd_raw.ins = 1'b1;
              cursor_next = c0 + ONE;
              length_next = l0 + ONE;
            end
          end
        endcase
      end
    endcase
  end

  // Shift the row only on an accepted keystroke
  assign cmd = step ? cmd_raw : '0;

  // Advance the editing state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      length   <= '0;
      phase    <= PH_IDLE;
      held     <= 8'h00;
      finished <= 1'b0;
    end else if (step) begin
      cursor   <= cursor_next;
      length   <= length_next;
      phase    <= phase_next;
      held     <= held_next;
      finished <= finished_next;
    end
  end

  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    cursor <= length)
    else $error("cursor beyond line end");

  a_length_limit: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_LIMIT)
    else $error("line length beyond store limit");

  a_digit_held: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DIGIT |-> (held >= CHAR_0) && (held <= CHAR_9))
    else $error("digit phase without a held digit");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    finished |-> phase == PH_IDLE)
    else $error("line ended inside an escape sequence");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - line editor keystroke and read-out check
// Drives keystroke and read transfers with random gaps and output stalls,
// keeps its own model of the line, cursor and escape decoder, and checks
// every output transfer field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;
  import tle_pkg::*;

  localparam int CAPACITY     = 1024;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] cursor;
    logic [9:0] length;
    logic [7:0] ch;
  } line_result_t;

  typedef struct packed {
    logic       op;
    logic [7:0] key;
    logic [9:0] idx;
  } keystroke_t;

  typedef struct packed {
    keystroke_t   stim;
    logic         typed;
    line_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // key_byte[7:0], read_index[17:8], zero pad
  logic [0:0]  s_axis_tuser;   // operation[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // cursor_position[9:0], line_length[19:10],
                               // read_char[27:20], zero pad
  logic [1:0]  m_axis_tuser;   // status[1:0]

  // Model of the line held by the editor
  logic [7:0]  line_mem [CAPACITY];
  int unsigned cur_pos;
  int unsigned line_len;
  logic [1:0]  esc_phase;
  logic [7:0]  lead_digit;
  logic        line_done;

  line_result_t result_fifo [$];
  plan_row_t    plan [$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  items_sent;
  int unsigned  send_run = 0;
  bit           send_calm = 1'b0;
  int unsigned  recv_run = 0;
  bit           recv_calm = 1'b0;
  int unsigned  stall_left = 0;

  terminal_line_editor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Close the gap at pos, shifting the tail down by one
  function automatic void cut_char(input int unsigned pos);
    if (pos >= line_len) return;
    for (int unsigned i = pos; i + 1 < line_len; i++) line_mem[i] = line_mem[i + 1];
    line_len--;
  endfunction

  // Advance the escape decoder by one byte
  function automatic void take_escape_byte(input logic [7:0] k);
    case (esc_phase)
      PH_ESC: begin
        esc_phase = (k == CHAR_BRACKET) ? PH_BRACKET : PH_IDLE;
      end
      PH_BRACKET: begin
        esc_phase = PH_IDLE;
        if (k == CHAR_C) begin
          if (cur_pos < line_len) cur_pos++;
        end else if (k == CHAR_D) begin
          if (cur_pos > 0) cur_pos--;
        end else if (k >= CHAR_0 && k <= CHAR_9) begin
          lead_digit = k;
          esc_phase  = PH_DIGIT;
        end
      end
      default: begin
        if (lead_digit == CHAR_3 && k == CHAR_TILDE) cut_char(cur_pos);
        lead_digit = 8'd0;
        esc_phase  = PH_IDLE;
      end
    endcase
  endfunction

  // Apply one keystroke to the line model and return the result kind
  function automatic logic [1:0] take_key(input logic [7:0] k);
    if (line_done) begin
      line_done  = 1'b0;
      cur_pos    = 0;
      line_len   = 0;
      esc_phase  = PH_IDLE;
      lead_digit = 8'd0;
    end
    if (esc_phase != PH_IDLE) begin
      take_escape_byte(k);
      return ST_EDIT;
    end
    if (k == KEY_ABORT || k == KEY_ABORT_ALT) begin
      line_done = 1'b1;
      return ST_ABORT;
    end
    if (k == KEY_NEWLINE) begin
      line_done = 1'b1;
      return ST_DONE;
    end
    if (k == KEY_BACKSPACE) begin
      if (cur_pos > 0) begin
        cur_pos--;
        cut_char(cur_pos);
      end
      return ST_EDIT;
    end
    if (k == KEY_ESC) begin
      esc_phase = PH_ESC;
      return ST_EDIT;
    end
    // Insert ordinary bytes while there is room; full line drops them
    if (k != KEY_NUL && k != KEY_TAB && line_len < CAPACITY - 1) begin
      for (int unsigned i = line_len; i > cur_pos; i--) line_mem[i] = line_mem[i - 1];
      line_mem[cur_pos] = k;
      cur_pos++;
      line_len++;
    end
    return ST_EDIT;
  endfunction

  function automatic line_result_t predict_line(input keystroke_t item);
    line_result_t r;
    r.ch = 8'd0;
    if (item.op == OP_READ) begin
      r.status = ST_READ;
      if (item.idx < line_len) r.ch = line_mem[item.idx];
    end else begin
      r.status = take_key(item.key);
    end
    r.cursor = cur_pos[9:0];
    r.length = line_len[9:0];
    return r;
  endfunction

  // Gap length: mostly none or short, a few long, with calm stretches
  function automatic int unsigned idle_span(inout int unsigned run_left, inout bit calm);
    int unsigned r;
    if (run_left == 0) begin
      calm     = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(20, 80);
    end
    run_left--;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one transfer, wait for the handshake, record the expected result
  task automatic send_item(input keystroke_t item, input logic typed,
                           input line_result_t want);
    line_result_t predicted;
    int unsigned gap;
    gap = idle_span(send_run, send_calm);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = item.op;
    s_axis_tdata  = {6'd0, item.idx, item.key};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = predict_line(item);
    result_fifo.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic press(input logic [7:0] k);
    send_item({OP_KEY, k, 10'($urandom_range(0, 1023))}, 1'b0, '0);
    items_sent++;
  endtask

  task automatic peek(input logic [9:0] idx);
    send_item({OP_READ, 8'($urandom_range(0, 255)), idx}, 1'b0, '0);
    items_sent++;
  endtask

  task automatic press_seq(input logic [7:0] final_byte);
    press(KEY_ESC);
    press(CHAR_BRACKET);
    press(final_byte);
  endtask

  // Hold the input side until every expected result is out
  task automatic drain_wait();
    s_axis_tvalid = 1'b0;
    while (result_fifo.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(input logic op, input logic [7:0] key, input logic [9:0] idx,
                         input logic typed, input logic [1:0] st, input logic [9:0] cur,
                         input logic [9:0] len, input logic [7:0] ch);
    plan.push_back({op, key, idx, typed, st, cur, len, ch});
  endtask

  task automatic flag_mismatch(input string what, input line_result_t due,
                               input line_result_t seen);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t %s: expected st %0d cur %0d len %0d ch %02h, got st %0d cur %0d len %0d ch %02h",
               $time, what, due.status, due.cursor, due.length, due.ch,
               seen.status, seen.cursor, seen.length, seen.ch);
  endtask

  // Stall the output side at random
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else begin
      stall_left    = idle_span(recv_run, recv_calm);
      m_axis_tready = (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Compare each output transfer with the oldest expectation
  always @(posedge clk) begin : check_output
    line_result_t seen;
    line_result_t due;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen = {m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tdata[27:20]};
      if (result_fifo.size() == 0) begin
        flag_mismatch("unexpected result", '0, seen);
      end else begin
        due = result_fifo.pop_front();
        if (seen !== due) flag_mismatch("result mismatch", due, seen);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    bit filled;
    bit paused;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cur_pos       = 0;
    line_len      = 0;
    esc_phase     = PH_IDLE;
    lead_digit    = 8'd0;
    line_done     = 1'b0;
    filled        = 1'b0;
    paused        = 1'b0;
    items_sent    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: empty line, ignored keys, extremes, escapes, line end
    add_row(OP_READ, 8'd0,        10'd0,    1'b1, ST_READ, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  KEY_NUL,     10'd0,    1'b1, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  KEY_TAB,     10'd1023, 1'b1, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  KEY_BACKSPACE, 10'd0,  1'b1, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  KEY_ESC,     10'd0,    1'b1, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  CHAR_D,      10'd0,    1'b1, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  8'h01,       10'd0,    1'b1, ST_EDIT, 10'd1, 10'd1, 8'd0);
    add_row(OP_KEY,  8'hFE,       10'd0,    1'b1, ST_EDIT, 10'd2, 10'd2, 8'd0);
    add_row(OP_KEY,  8'h41,       10'd0,    1'b0, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  KEY_ESC,     10'd0,    1'b0, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  CHAR_BRACKET, 10'd0,   1'b0, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  CHAR_D,      10'd0,    1'b0, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  KEY_ESC,     10'd0,    1'b0, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  CHAR_BRACKET, 10'd0,   1'b0, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  CHAR_3,      10'd0,    1'b0, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  CHAR_TILDE,  10'd0,    1'b0, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_READ, 8'hFF,       10'd1,    1'b0, ST_READ, 10'd0, 10'd0, 8'd0);
    add_row(OP_READ, 8'd0,        10'd1022, 1'b0, ST_READ, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  KEY_ESC,     10'd0,    1'b0, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  KEY_ABORT,   10'd0,    1'b0, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  KEY_NEWLINE, 10'd0,    1'b0, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_READ, 8'd0,        10'd0,    1'b0, ST_READ, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  8'h5A,       10'd0,    1'b0, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  KEY_ABORT_ALT, 10'd0,  1'b0, ST_EDIT, 10'd0, 10'd0, 8'd0);
    add_row(OP_KEY,  KEY_ABORT,   10'd0,    1'b1, ST_ABORT, 10'd0, 10'd0, 8'd0);
    foreach (plan[i]) send_item(plan[i].stim, plan[i].typed, plan[i].want);
    drain_wait();

    // Random editing sessions, mostly well-formed sequences
    while (items_sent < RANDOM_ITEMS) begin
      if (!filled && items_sent > 300) begin
        // Grow one line to capacity, editing in the middle on the way
        filled = 1'b1;
        press(KEY_NEWLINE);
        for (int i = 0; i < 1030; i++) begin
          if (i == 600) repeat (5) press_seq(CHAR_D);
          press(8'($urandom_range(8'h20, 8'h7E)));
        end
        peek(10'd1022);
        peek(10'd0);
        press_seq(CHAR_D);
        press(KEY_ESC);
        press(CHAR_BRACKET);
        press(CHAR_3);
        press(CHAR_TILDE);
        press(8'h80);
        press(8'h78);
        repeat (10) press_seq(CHAR_C);
        press(KEY_BACKSPACE);
        press(8'h79);
        press(8'h7A);
        peek(10'd1022);
        press(KEY_NEWLINE);
      end
      if (!paused && items_sent > 1400) begin
        paused = 1'b1;
        drain_wait();
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        repeat ($urandom_range(1, 6)) press(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 45) begin
        press(KEY_BACKSPACE);
      end else if (pick < 53) begin
        press_seq(CHAR_C);
      end else if (pick < 61) begin
        press_seq(CHAR_D);
      end else if (pick < 67) begin
        press(KEY_ESC);
        press(CHAR_BRACKET);
        press(CHAR_3);
        press(CHAR_TILDE);
      end else if (pick < 70) begin
        // Other final bytes; a digit opens the digit phase
        press_seq(($urandom_range(0, 1) == 0) ? 8'h41 : 8'($urandom_range(0, 255)));
        press(8'($urandom_range(0, 255)));
      end else if (pick < 72) begin
        press(KEY_ESC);
        press(CHAR_BRACKET);
        press(8'($urandom_range(CHAR_0, CHAR_9)));
        press(($urandom_range(0, 1) == 0) ? CHAR_TILDE : 8'($urandom_range(0, 255)));
      end else if (pick < 74) begin
        press(KEY_ESC);
        press(8'($urandom_range(0, 255)));
      end else if (pick < 84) begin
        if (line_len > 0 && $urandom_range(0, 9) < 7)
          peek(10'($urandom_range(0, line_len)));
        else
          peek(10'($urandom_range(0, 1022)));
      end else if (pick < 86) begin
        press(($urandom_range(0, 1) == 0) ? KEY_NUL : KEY_TAB);
      end else if (pick < 89) begin
        press(KEY_NEWLINE);
      end else if (pick < 90) begin
        press(($urandom_range(0, 1) == 0) ? KEY_ABORT : KEY_ABORT_ALT);
      end else if (pick < 98) begin
        press(8'($urandom_range(0, 255)));
      end else begin
        // Line-control bytes swallowed inside a sequence
        press(KEY_ESC);
        case ($urandom_range(0, 3))
          0: press(KEY_ABORT);
          1: press(KEY_ABORT_ALT);
          2: press(KEY_NEWLINE);
          default: press(KEY_ESC);
        endcase
      end
    end

    drain_wait();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
